@@ src/tbhtd_pkg.sv @@
package tbhtd_pkg;

   localparam int HoldW  = 16;
   localparam int PressW = 10;
   localparam int PhaseW = 10;
   localparam int CountW = 4;
   localparam int WaitW  = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // register indexes on the configuration port
   localparam logic [CsrIdxW-1:0] REG_ENABLED   = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_HOLD_MS   = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_SHORT_MAX = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_MIN_PRESS = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_PHASE_MS  = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_PHASES    = 3'd5;

   localparam logic [HoldW-1:0]  RST_HOLD_MS   = 16'd3000;
   localparam logic [PressW-1:0] RST_SHORT_MAX = 10'd600;
   localparam logic [PressW-1:0] RST_MIN_PRESS = 10'd50;
   localparam logic [PhaseW-1:0] RST_PHASE_MS  = 10'd200;
   localparam logic [CountW-1:0] RST_PHASES    = 4'd4;

   localparam logic [WaitW-1:0]  RESTART_EXTRA = 16'd200;
   localparam logic [HoldW-1:0]  HOLD_MAX      = '1;
   localparam logic [PressW-1:0] PRESS_MAX     = '1;

   typedef struct packed {
      logic              enabled;
      logic [HoldW-1:0]  hold_ms;
      logic [PressW-1:0] short_press_max_ms;
      logic [PressW-1:0] min_press_ms;
      logic [PhaseW-1:0] flash_phase_ms;
      logic [CountW-1:0] flash_phases;
   } cfg_type;

   typedef struct packed {
      logic              combo_held;
      logic [HoldW-1:0]  combo_elapsed;
      logic              hold_fired;
      logic              killed;
      logic              first_held;
      logic [PressW-1:0] press_elapsed;
      logic              flash_running;
      logic              flash_phase_on;
      logic              flash_colour_green;
      logic [CountW-1:0] phases_left;
      logic [PhaseW-1:0] phase_wait;
      logic              restart_pending;
      logic [WaitW-1:0]  restart_wait;
   } state_type;

   // packed so that kill_state lands in bit 0
   typedef struct packed {
      logic restart_request;
      logic restore_lamp;
      logic flash_green;
      logic flash_lit;
      logic flash_override;
      logic tap_toggle;
      logic kill_toggled;
      logic kill_state;
   } result_type;

endpackage

@@ src/tbhtd_step.sv @@
module tbhtd_step (
   input  tbhtd_pkg::cfg_type    cfg,
   input  tbhtd_pkg::state_type  cur,
   input  logic                  first_pressed,
   input  logic                  second_pressed,
   output tbhtd_pkg::state_type  nxt,
   output tbhtd_pkg::result_type res
);

   localparam int TotalW = tbhtd_pkg::CountW + tbhtd_pkg::PhaseW;

   logic [tbhtd_pkg::PhaseW-1:0] phase_len;
   logic [TotalW-1:0] flash_total;
   logic [tbhtd_pkg::WaitW-1:0] restart_len;

   assign phase_len   = (cfg.flash_phase_ms == '0) ? tbhtd_pkg::PhaseW'(1) : cfg.flash_phase_ms;
   assign flash_total = TotalW'(cfg.flash_phases) * TotalW'(cfg.flash_phase_ms);
   assign restart_len = tbhtd_pkg::WaitW'(flash_total) + tbhtd_pkg::RESTART_EXTRA;

   always_comb begin
      logic tog;
      logic tap;
      logic restore;
      logic restart;
      tog     = 1'b0;
      tap     = 1'b0;
      restore = 1'b0;
      restart = 1'b0;
      nxt     = cur;

      // flash sequencer
      if (cur.flash_running) begin
         if (cur.phase_wait != '0) begin
            nxt.phase_wait = cur.phase_wait - 1'b1;
         end else if (cur.phases_left == '0) begin
            nxt.flash_running = 1'b0;
            restore           = 1'b1;
         end else begin
            nxt.flash_phase_on = ~cur.flash_phase_on;
            nxt.phases_left    = cur.phases_left - 1'b1;
            nxt.phase_wait     = phase_len - 1'b1;
         end
      end

      // restart countdown
      if (cur.restart_pending) begin
         if (cur.restart_wait != '0) begin
            nxt.restart_wait = cur.restart_wait - 1'b1;
         end
         if (nxt.restart_wait == '0) begin
            nxt.restart_pending = 1'b0;
            restart             = 1'b1;
         end
      end

      if (!restart && cfg.enabled) begin
         if (first_pressed && second_pressed) begin
            if (!cur.combo_held) begin
               nxt.combo_held    = 1'b1;
               nxt.combo_elapsed = '0;
               nxt.hold_fired    = 1'b0;
            end else begin
               if (cur.combo_elapsed != tbhtd_pkg::HOLD_MAX) begin
                  nxt.combo_elapsed = cur.combo_elapsed + 1'b1;
               end
               if (!cur.hold_fired && nxt.combo_elapsed >= cfg.hold_ms) begin
                  nxt.hold_fired         = 1'b1;
                  tog                    = 1'b1;
                  nxt.killed             = ~cur.killed;
                  nxt.flash_colour_green = cur.killed;
                  nxt.phases_left        = cfg.flash_phases;
                  nxt.flash_phase_on     = 1'b0;
                  nxt.flash_running      = 1'b1;
                  nxt.phase_wait         = '0;
                  // kill off: schedule restart after the green flash
                  if (cur.killed) begin
                     nxt.restart_pending = 1'b1;
                     nxt.restart_wait    = restart_len;
                  end
               end
            end
         end else begin
            nxt.combo_held = 1'b0;
         end

         if (first_pressed) begin
            if (!cur.first_held) begin
               nxt.first_held    = 1'b1;
               nxt.press_elapsed = '0;
            end else if (cur.press_elapsed != tbhtd_pkg::PRESS_MAX) begin
               nxt.press_elapsed = cur.press_elapsed + 1'b1;
            end
         end else if (cur.first_held) begin
            if (cur.press_elapsed != tbhtd_pkg::PRESS_MAX) begin
               nxt.press_elapsed = cur.press_elapsed + 1'b1;
            end
            nxt.first_held = 1'b0;
            if (!nxt.hold_fired && nxt.press_elapsed >= cfg.min_press_ms &&
                nxt.press_elapsed < cfg.short_press_max_ms) begin
               tap = 1'b1;
            end
            nxt.hold_fired = 1'b0;
         end
      end

      res.kill_state      = nxt.killed;
      res.kill_toggled    = tog;
      res.tap_toggle      = tap;
      res.flash_override  = nxt.flash_running;
      res.flash_lit       = nxt.flash_running & nxt.flash_phase_on;
      res.flash_green     = nxt.flash_running & nxt.flash_colour_green;
      res.restore_lamp    = restore;
      res.restart_request = restart;
   end

endmodule

@@ src/two_button_hold_and_tap_detector_core.sv @@
// Two-button hold and tap detector. Each request is one millisecond tick carrying both
// button levels and produces exactly one response with the kill flag, toggle and tap
// pulses, flash feedback controls and the restart pulse. A request is registered, the
// whole tick update runs as one combinational pass, and the response is registered; one
// request is taken every cycle as long as the response side keeps up. The user must write
// configuration registers through csr_ only while idle; the block does not enforce it.
module two_button_hold_and_tap_detector_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [0] first_pressed, [1] second_pressed
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] kill_state, [1] kill_toggled, [2] tap_toggle, [3] flash_override,
   // [4] flash_lit, [5] flash_green, [6] restore_lamp, [7] restart_request
   output logic [7:0]                        rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [tbhtd_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [tbhtd_pkg::CsrDataW-1:0]    csr_wdata
);

   tbhtd_pkg::cfg_type    cfg_ff;
   tbhtd_pkg::state_type  state_ff;
   tbhtd_pkg::state_type  state_in;
   tbhtd_pkg::result_type res_in;
   tbhtd_pkg::result_type res_ff;

   logic in_valid_ff;
   logic in_first_ff;
   logic in_second_ff;
   logic out_valid_ff;
   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = res_ff;

   tbhtd_step u_step (
      .cfg            (cfg_ff),
      .cur            (state_ff),
      .first_pressed  (in_first_ff),
      .second_pressed (in_second_ff),
      .nxt            (state_in),
      .res            (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled            <= 1'b1;
         cfg_ff.hold_ms            <= tbhtd_pkg::RST_HOLD_MS;
         cfg_ff.short_press_max_ms <= tbhtd_pkg::RST_SHORT_MAX;
         cfg_ff.min_press_ms       <= tbhtd_pkg::RST_MIN_PRESS;
         cfg_ff.flash_phase_ms     <= tbhtd_pkg::RST_PHASE_MS;
         cfg_ff.flash_phases       <= tbhtd_pkg::RST_PHASES;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tbhtd_pkg::REG_ENABLED:   cfg_ff.enabled <= csr_wdata[0];
            tbhtd_pkg::REG_HOLD_MS:   cfg_ff.hold_ms <= csr_wdata[tbhtd_pkg::HoldW-1:0];
            tbhtd_pkg::REG_SHORT_MAX: begin
               cfg_ff.short_press_max_ms <= csr_wdata[tbhtd_pkg::PressW-1:0];
            end
            tbhtd_pkg::REG_MIN_PRESS: cfg_ff.min_press_ms <= csr_wdata[tbhtd_pkg::PressW-1:0];
            tbhtd_pkg::REG_PHASE_MS:  cfg_ff.flash_phase_ms <= csr_wdata[tbhtd_pkg::PhaseW-1:0];
            tbhtd_pkg::REG_PHASES:    cfg_ff.flash_phases <= csr_wdata[tbhtd_pkg::CountW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_first_ff  <= req_tdata[0];
         in_second_ff <= req_tdata[1];
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

endmodule

@@ dv/testbench.sv @@
module testbench;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF    = 250;

   typedef struct packed {
      logic second;
      logic first;
   } buttons_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [7:0]                     rsp_tdata;
   logic                           csr_wr_en  = 1'b0;
   logic [tbhtd_pkg::CsrIdxW-1:0]  csr_index  = '0;
   logic [tbhtd_pkg::CsrDataW-1:0] csr_wdata  = '0;

   two_button_hold_and_tap_detector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   buttons_type           tick_q[$];
   tbhtd_pkg::result_type expected_rsp_q[$];
   logic                  req_fire       = 1'b0;
   logic                  sender_idles   = 1'b1;
   logic                  receiver_idles = 1'b1;
   int                    fail_count     = 0;
   int                    rsp_seen       = 0;
   int                    idle_cycles    = 0;

   string field_name [8] = '{"kill_state", "kill_toggled", "tap_toggle", "flash_override",
                             "flash_lit", "flash_green", "restore_lamp", "restart_request"};

   // ---------------------------------------------------------------- predictor state
   tbhtd_pkg::cfg_type                shadow_cfg;
   logic                              pair_down;
   logic [tbhtd_pkg::HoldW-1:0]       pair_ticks;
   logic                              pair_fired;
   logic                              kill_on;
   logic                              b1_down;
   logic [tbhtd_pkg::PressW-1:0]      b1_ticks;
   logic                              fl_active;
   logic                              fl_lit;
   logic                              fl_green;
   logic [tbhtd_pkg::CountW-1:0]      fl_left;
   logic [tbhtd_pkg::PhaseW-1:0]      fl_wait;
   logic                              reboot_armed;
   logic [tbhtd_pkg::WaitW-1:0]       reboot_wait;

   function automatic void clear_model();
      shadow_cfg.enabled            = 1'b1;
      shadow_cfg.hold_ms            = tbhtd_pkg::RST_HOLD_MS;
      shadow_cfg.short_press_max_ms = tbhtd_pkg::RST_SHORT_MAX;
      shadow_cfg.min_press_ms       = tbhtd_pkg::RST_MIN_PRESS;
      shadow_cfg.flash_phase_ms     = tbhtd_pkg::RST_PHASE_MS;
      shadow_cfg.flash_phases       = tbhtd_pkg::RST_PHASES;
      pair_down    = 1'b0;
      pair_ticks   = '0;
      pair_fired   = 1'b0;
      kill_on      = 1'b0;
      b1_down      = 1'b0;
      b1_ticks     = '0;
      fl_active    = 1'b0;
      fl_lit       = 1'b0;
      fl_green     = 1'b0;
      fl_left      = '0;
      fl_wait      = '0;
      reboot_armed = 1'b0;
      reboot_wait  = '0;
   endfunction

   function automatic void start_flash(input logic green);
      fl_green  = green;
      fl_left   = shadow_cfg.flash_phases;
      fl_lit    = 1'b0;
      fl_active = 1'b1;
      fl_wait   = '0;
   endfunction

   function automatic tbhtd_pkg::result_type predict_tick(input logic p1, input logic p2);
      tbhtd_pkg::result_type        r;
      logic                         toggled;
      logic                         tapped;
      logic                         restored;
      logic                         rebooted;
      logic [tbhtd_pkg::PhaseW-1:0] len;
      int                           span;
      toggled  = 1'b0;
      tapped   = 1'b0;
      restored = 1'b0;
      rebooted = 1'b0;

      if (fl_active) begin
         if (fl_wait != 0) begin
            fl_wait = fl_wait - 1'b1;
         end else if (fl_left == 0) begin
            fl_active = 1'b0;
            restored  = 1'b1;
         end else begin
            len     = (shadow_cfg.flash_phase_ms == 0) ? tbhtd_pkg::PhaseW'(1)
                                                       : shadow_cfg.flash_phase_ms;
            fl_lit  = ~fl_lit;
            fl_left = fl_left - 1'b1;
            fl_wait = len - 1'b1;
         end
      end

      if (reboot_armed) begin
         if (reboot_wait != 0)
            reboot_wait = reboot_wait - 1'b1;
         if (reboot_wait == 0) begin
            reboot_armed = 1'b0;
            rebooted     = 1'b1;
         end
      end

      // buttons are not looked at on the restart tick
      if (!rebooted && shadow_cfg.enabled) begin
         if (p1 && p2) begin
            if (!pair_down) begin
               pair_down  = 1'b1;
               pair_ticks = '0;
               pair_fired = 1'b0;
            end else begin
               if (pair_ticks != tbhtd_pkg::HOLD_MAX)
                  pair_ticks = pair_ticks + 1'b1;
               if (!pair_fired && pair_ticks >= shadow_cfg.hold_ms) begin
                  pair_fired = 1'b1;
                  toggled    = 1'b1;
                  if (!kill_on) begin
                     kill_on = 1'b1;
                     start_flash(1'b0);
                  end else begin
                     kill_on = 1'b0;
                     start_flash(1'b1);
                     span = int'(shadow_cfg.flash_phases) * int'(shadow_cfg.flash_phase_ms)
                            + int'(tbhtd_pkg::RESTART_EXTRA);
                     reboot_armed = 1'b1;
                     reboot_wait  = tbhtd_pkg::WaitW'(span);
                  end
               end
            end
         end else begin
            pair_down = 1'b0;
         end

         if (p1) begin
            if (!b1_down) begin
               b1_down  = 1'b1;
               b1_ticks = '0;
            end else if (b1_ticks != tbhtd_pkg::PRESS_MAX) begin
               b1_ticks = b1_ticks + 1'b1;
            end
         end else if (b1_down) begin
            if (b1_ticks != tbhtd_pkg::PRESS_MAX)
               b1_ticks = b1_ticks + 1'b1;
            b1_down = 1'b0;
            // a saturated press falls outside any window since max is at most PRESS_MAX
            if (!pair_fired && b1_ticks >= shadow_cfg.min_press_ms &&
                b1_ticks < shadow_cfg.short_press_max_ms)
               tapped = 1'b1;
            pair_fired = 1'b0;
         end
      end

      r.kill_state      = kill_on;
      r.kill_toggled    = toggled;
      r.tap_toggle      = tapped;
      r.flash_override  = fl_active;
      r.flash_lit       = fl_active & fl_lit;
      r.flash_green     = fl_active & fl_green;
      r.restore_lamp    = restored;
      r.restart_request = rebooted;
      return r;
   endfunction

   // ---------------------------------------------------------------- monitor / checker
   always @(posedge clock) begin : monitor
      tbhtd_pkg::result_type want;
      tbhtd_pkg::result_type got;
      if (reset) begin
         clear_model();
         expected_rsp_q.delete();
         req_fire    <= 1'b0;
         idle_cycles = 0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               tbhtd_pkg::REG_ENABLED:   shadow_cfg.enabled        = csr_wdata[0];
               tbhtd_pkg::REG_HOLD_MS:
                  shadow_cfg.hold_ms = csr_wdata[tbhtd_pkg::HoldW-1:0];
               tbhtd_pkg::REG_SHORT_MAX:
                  shadow_cfg.short_press_max_ms = csr_wdata[tbhtd_pkg::PressW-1:0];
               tbhtd_pkg::REG_MIN_PRESS:
                  shadow_cfg.min_press_ms = csr_wdata[tbhtd_pkg::PressW-1:0];
               tbhtd_pkg::REG_PHASE_MS:
                  shadow_cfg.flash_phase_ms = csr_wdata[tbhtd_pkg::PhaseW-1:0];
               tbhtd_pkg::REG_PHASES:
                  shadow_cfg.flash_phases = csr_wdata[tbhtd_pkg::CountW-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(predict_tick(req_tdata[0], req_tdata[1]));
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            got = tbhtd_pkg::result_type'(rsp_tdata);
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response %b at response %0d", rsp_tdata, rsp_seen);
            end else begin
               want = expected_rsp_q.pop_front();
               for (int b = 0; b < 8; b++) begin
                  if (got[b] !== want[b]) begin
                     fail_count++;
                     if (fail_count <= 10)
                        $display("response %0d %s: expected %b, got %b",
                                 rsp_seen, field_name[b], want[b], got[b]);
                  end
               end
            end
         end
         req_fire <= req_tvalid && req_tready;

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // ---------------------------------------------------------------- request driver
   int pause_left = 0;

   always @(negedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         pause_left <= 0;
      end else if (req_tvalid && !req_fire) begin
         // hold the request until it is taken
      end else if (pause_left > 0) begin
         req_tvalid <= 1'b0;
         pause_left <= pause_left - 1;
      end else if (tick_q.size() > 0) begin
         req_tdata  <= {6'b0, tick_q[0].second, tick_q[0].first};
         req_tvalid <= 1'b1;
         pause_left <= (sender_idles && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
         void'(tick_q.pop_front());
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- response sink
   int   stall_left   = 0;
   int   hold_left    = 0;
   logic squeeze_done = 1'b0;

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!squeeze_done && rsp_seen >= 300) begin
         // long hold-off so the core backs up into the request side
         squeeze_done <= 1'b1;
         hold_left    <= HOLD_OFF - 1;
         rsp_tready   <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (receiver_idles && $urandom_range(0, 99) < 12) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic push_ticks(input logic p1, input logic p2, input int n);
      buttons_type t;
      t.first  = p1;
      t.second = p2;
      repeat (n) tick_q.push_back(t);
   endtask

   task automatic write_reg(input logic [tbhtd_pkg::CsrIdxW-1:0] idx, input int val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= tbhtd_pkg::CsrDataW'(val);
   endtask

   task automatic load_settings(input int en, input int hold, input int short_max,
                                input int min_press, input int phase_ms, input int phases);
      write_reg(tbhtd_pkg::REG_ENABLED, en);
      write_reg(tbhtd_pkg::REG_HOLD_MS, hold);
      write_reg(tbhtd_pkg::REG_SHORT_MAX, short_max);
      write_reg(tbhtd_pkg::REG_MIN_PRESS, min_press);
      write_reg(tbhtd_pkg::REG_PHASE_MS, phase_ms);
      write_reg(tbhtd_pkg::REG_PHASES, phases);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every request is taken and every response is back
   task automatic drain();
      while (tick_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic int clamp_len(input int n);
      if (n < 1)
         return 1;
      if (n > 80)
         return 80;
      return n;
   endfunction

   // mostly well-formed taps and combo holds sized around the current windows
   task automatic add_button_traffic(input int budget, input int hold, input int min_len,
                                     input int max_len);
      int start;
      int len;
      start = tick_q.size();
      while (tick_q.size() - start < budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               case ($urandom_range(0, 2))
                  0:       len = min_len + int'($urandom_range(0, 2)) - 1;
                  1:       len = max_len + int'($urandom_range(0, 2)) - 1;
                  default: len = int'($urandom_range(min_len, max_len));
               endcase
               push_ticks(1'b1, 1'b0, clamp_len(len));
               push_ticks(1'b0, 1'b0, 1);
            end
            4, 5: begin
               if ($urandom_range(0, 1))
                  push_ticks(1'b1, 1'b0, $urandom_range(0, 3));
               else
                  push_ticks(1'b0, 1'b1, $urandom_range(0, 3));
               push_ticks(1'b1, 1'b1, clamp_len(hold + int'($urandom_range(0, 3))));
               case ($urandom_range(0, 2))
                  0:       push_ticks(1'b1, 1'b0, $urandom_range(1, 4));
                  1:       push_ticks(1'b0, 1'b1, $urandom_range(1, 4));
                  default: ;
               endcase
               push_ticks(1'b0, 1'b0, 1);
            end
            6: push_ticks(1'b0, 1'b0, $urandom_range(1, 15));
            7: repeat ($urandom_range(1, 10))
                  push_ticks(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
            8: push_ticks(1'b0, 1'b1, $urandom_range(1, 8));
            default: begin
               push_ticks(1'b1, 1'b1, $urandom_range(1, (hold > 1) ? hold : 1));
               push_ticks(1'b0, 1'b0, 1);
            end
         endcase
      end
   endtask

   initial begin : sequencer
      int hold;
      int short_max;
      int min_press;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // a few ticks at reset settings
      push_ticks(1'b0, 1'b0, 1);
      push_ticks(1'b1, 1'b0, 1);
      push_ticks(1'b0, 1'b1, 1);
      push_ticks(1'b1, 1'b1, 1);
      push_ticks(1'b0, 1'b0, 1);
      drain();

      // directed: zero hold time, zero phase length, tap window edges, kill on then off
      load_settings(1, 0, 4, 1, 0, 1);
      push_ticks(1'b1, 1'b1, 3);
      push_ticks(1'b0, 1'b1, 1);
      push_ticks(1'b0, 1'b0, 1);
      push_ticks(1'b1, 1'b0, 2);
      push_ticks(1'b0, 1'b0, 1);
      push_ticks(1'b1, 1'b0, 1);
      push_ticks(1'b0, 1'b0, 1);
      push_ticks(1'b1, 1'b0, 4);
      push_ticks(1'b0, 1'b0, 1);
      push_ticks(1'b0, 1'b1, 1);
      push_ticks(1'b1, 1'b1, 2);
      push_ticks(1'b1, 1'b0, 1);
      push_ticks(1'b0, 1'b0, 2);
      drain();

      load_settings(1, 5, 8, 2, 3, 2);
      add_button_traffic(220, 5, 2, 8);
      drain();

      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      load_settings(1, 1, 1, 0, 1, 0);
      add_button_traffic(220, 1, 0, 1);
      drain();

      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      load_settings(0, 3, 6, 1, 2, 3);
      add_button_traffic(60, 3, 1, 6);
      drain();

      load_settings(1, 0, 12, 3, 0, 15);
      add_button_traffic(220, 0, 3, 12);
      drain();

      load_settings(1, 4, 1023, 1023, 1, 1);
      add_button_traffic(200, 4, 1023, 1023);
      drain();

      repeat (4) begin
         sender_idles   = $urandom_range(0, 3) != 0;
         receiver_idles = $urandom_range(0, 3) != 0;
         hold      = $urandom_range(0, 12);
         short_max = $urandom_range(1, 14);
         min_press = $urandom_range(0, 8);
         load_settings(($urandom_range(0, 9) != 0) ? 1 : 0, hold, short_max, min_press,
                       $urandom_range(0, 4), $urandom_range(0, 15));
         add_button_traffic(220, hold, min_press, short_max);
         drain();
      end

      repeat (4) @(posedge clock);
      fail_count += expected_rsp_q.size();
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ two_button_hold_and_tap_detector_core.f @@
src/tbhtd_pkg.sv
src/tbhtd_step.sv
src/two_button_hold_and_tap_detector_core.sv
dv/testbench.sv
